### rtl/srgbx_pkg.sv
// types, constants and the linearization function for the srgb to xyz converter
`timescale 1ns / 1ps

package srgbx_pkg;

  localparam int CHANNEL_BITS  = 12;
  localparam int OUT_FRAC_BITS = 14;
  localparam int CHAN_CODES    = 2 ** CHANNEL_BITS;

  localparam int LIN_FRAC  = 24;
  localparam int LIN_W     = LIN_FRAC + 1;
  localparam int COEF_W    = 14;
  localparam int SUM_W     = LIN_FRAC + COEF_W;
  localparam int LIN_SHIFT = LIN_FRAC - OUT_FRAC_BITS;
  localparam int SCALE_W   = SUM_W - LIN_SHIFT + 1;

  localparam int COEF_SCALE = 10000;
  localparam int ROUND_HALF = COEF_SCALE / 2;

  // reciprocal of the coefficient scale for the final divide
  localparam longint unsigned RECIP = (64'd1 << SCALE_W) / COEF_SCALE;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int MUL_W   = SCALE_W + RECIP_W;

  localparam int OUT_W   = 15;
  localparam int OUT_MAX = 2 ** OUT_W - 1;

  localparam int IN_DATA_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam longint unsigned CHAN_MAX    = (64'd1 << CHANNEL_BITS) - 1;
  localparam longint unsigned LIN_ONE     = 64'd1 << LIN_FRAC;
  localparam longint unsigned LIN_HALF    = LIN_ONE >> 1;
  localparam longint unsigned LIN_THRESH  = 4045 * CHAN_MAX;
  localparam longint unsigned LIN_HI_DEN  = 1055 * CHAN_MAX;
  localparam longint unsigned LIN_HI_HALF = LIN_HI_DEN / 2;
  localparam longint unsigned LIN_LO_DEN  = 1292 * CHAN_MAX;
  localparam longint unsigned LIN_LO_HALF = LIN_LO_DEN / 2;

  typedef logic [CHANNEL_BITS-1:0] code_t;
  typedef logic [LIN_W-1:0]        lin_t;
  typedef logic [COEF_W-1:0]       coef_t;
  typedef logic [OUT_W-1:0]        tristim_t;

  typedef struct packed {
    lin_t red;
    lin_t green;
    lin_t blue;
  } lin_pix_t;

  // rows give x, y, z; columns red, green, blue; units of 1/10000
  localparam coef_t MAT_COEF [3][3] = '{
    '{14'd4124, 14'd3576, 14'd1805},
    '{14'd2126, 14'd7152, 14'd722},
    '{14'd193,  14'd1192, 14'd9505}
  };

  function automatic longint unsigned fifth_power(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r) >> LIN_FRAC;
    end
    return p;
  endfunction

  function automatic longint unsigned linearize_code(input longint unsigned c);
    longint unsigned t;
    longint unsigned q;
    longint unsigned r;
    longint unsigned cand;
    longint unsigned lin;
    r = 0;
    if (c * 100000 > LIN_THRESH) begin
      t = ((((1000 * c) + (55 * CHAN_MAX)) << LIN_FRAC) + LIN_HI_HALF) / LIN_HI_DEN;
      q = (t * t + LIN_HALF) >> LIN_FRAC;
      // fifth root of q by bitwise search, then q times root gives the 2.4 power
      for (int b = LIN_FRAC; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if (cand <= LIN_ONE && fifth_power(cand) <= q) begin
          r = cand;
        end
      end
      lin = (q * r + LIN_HALF) >> LIN_FRAC;
    end else begin
      lin = (((c * 100) << LIN_FRAC) + LIN_LO_HALF) / LIN_LO_DEN;
    end
    return lin;
  endfunction

endpackage

### rtl/srgbx_lin_rom.sv
// linearization rom for one channel, registered read
`timescale 1ns / 1ps

module srgbx_lin_rom
  import srgbx_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  code_t code,
  output lin_t  lin
);

  lin_t lin_table [CHAN_CODES];

  initial begin
    for (int i = 0; i < CHAN_CODES; i++) begin
      lin_table[i] = LIN_W'(linearize_code(longint'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin <= lin_table[code];
    end
  end

endmodule

### rtl/srgbx_front.sv
// front end: accepts pixels and linearizes each channel
`timescale 1ns / 1ps

module srgbx_front
  import srgbx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output lin_pix_t             pix
);

  logic  vld;
  logic  take;
  code_t red_code;
  code_t green_code;
  code_t blue_code;

  assign red_code   = s_axis_tdata[CHANNEL_BITS-1:0];
  assign green_code = s_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
  assign blue_code  = s_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];

  assign s_axis_tready = !vld || pix_ready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign pix_valid     = vld;

  srgbx_lin_rom u_rom_red (
    .clk  (clk),
    .en   (take),
    .code (red_code),
    .lin  (pix.red)
  );

  srgbx_lin_rom u_rom_green (
    .clk  (clk),
    .en   (take),
    .code (green_code),
    .lin  (pix.green)
  );

  srgbx_lin_rom u_rom_blue (
    .clk  (clk),
    .en   (take),
    .code (blue_code),
    .lin  (pix.blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_axis_tready) begin
      vld <= s_axis_tvalid;
    end
  end

endmodule

### rtl/srgbx_queue.sv
// short fifo of linearized pixels between front and back
`timescale 1ns / 1ps

module srgbx_queue
  import srgbx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  lin_pix_t wr_pix,
  output logic     rd_valid,
  input  logic     rd_ready,
  output lin_pix_t rd_pix
);

  lin_pix_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                wr_en;
  logic                rd_en;

  assign wr_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_pix   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/srgbx_back.sv
// back end: matrix multiply, rounding divide and output register
`timescale 1ns / 1ps

module srgbx_back
  import srgbx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  lin_pix_t              pix,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  lin_t                 lin_in [3];
  logic [SUM_W-1:0]     prod1  [3][3];
  logic [SUM_W-1:0]     sum1   [3];
  logic [SCALE_W-1:0]   w2     [3];
  logic [MUL_W-1:0]     m3     [3];
  logic [SCALE_W-1:0]   w3     [3];
  logic [RECIP_W-1:0]   quo3   [3];
  logic [RECIP_W-1:0]   q4     [3];
  logic [SCALE_W-1:0]   qm4    [3];
  logic [SCALE_W-1:0]   w4     [3];
  logic [SCALE_W-1:0]   rem4   [3];
  logic [31:0]          val4   [3];
  tristim_t             res4   [3];
  tristim_t             res5   [3];

  assign lin_in[0] = pix.red;
  assign lin_in[1] = pix.green;
  assign lin_in[2] = pix.blue;

  assign adv5 = !v5 || m_axis_tready;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pix_ready = adv1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum1[i] = prod1[i][0] + prod1[i][1] + prod1[i][2];
      quo3[i] = RECIP_W'(m3[i] >> SCALE_W);
      rem4[i] = w4[i] - qm4[i];
      // reciprocal estimate is exact or one short
      val4[i] = 32'(q4[i]) + 32'(rem4[i] >= SCALE_W'(COEF_SCALE));
      res4[i] = (val4[i] > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(val4[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod1[i][j] <= SUM_W'(MAT_COEF[i][j]) * SUM_W'(lin_in[j]);
        end
      end
    end
    if (adv2) begin
      for (int i = 0; i < 3; i++) begin
        w2[i] <= SCALE_W'(sum1[i] >> LIN_SHIFT) + SCALE_W'(ROUND_HALF);
      end
    end
    if (adv3) begin
      for (int i = 0; i < 3; i++) begin
        m3[i] <= MUL_W'(w2[i]) * MUL_W'(RECIP);
        w3[i] <= w2[i];
      end
    end
    if (adv4) begin
      for (int i = 0; i < 3; i++) begin
        q4[i]  <= quo3[i];
        qm4[i] <= SCALE_W'(SCALE_W'(quo3[i]) * SCALE_W'(COEF_SCALE));
        w4[i]  <= w3[i];
      end
    end
    if (adv5) begin
      for (int i = 0; i < 3; i++) begin
        res5[i] <= res4[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= pix_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv4) begin
        v4 <= v3;
      end
      if (adv5) begin
        v5 <= v4;
      end
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {(OUT_DATA_W - 3 * OUT_W)'(0), res5[2], res5[1], res5[0]};

endmodule

### rtl/srgb_to_xyz_converter.sv
// top level of the srgb to cie xyz (d65) pixel converter
//
// usage: pixels enter on the s_axis channel, one transaction per pixel, and
// leave as xyz tristimulus values on the m_axis channel, one transaction per
// pixel, in the same order. tdata on s_axis carries red, green and blue codes
// of 12 bits each; tdata on m_axis carries x, y and z of 15 bits each with
// 14 fraction bits.
// throughput: one pixel per clock while m_axis_tready is high, limited by the
// per-channel rom read and the single-issue matrix pipeline.
// each pixel passes the rom read and the queue write, then five back-end stages,
// before its result is offered on m_axis.
// reset clears all valid flags and empties the queue; the linearization roms
// are constant and need no clearing, so a pixel is taken on the first cycle
// after reset.
// when the receiver stalls, the back end holds its stages, the queue fills to four
// pixels, the front register holds one more, then s_axis_tready falls until space frees up.
`timescale 1ns / 1ps

module srgb_to_xyz_converter
  import srgbx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // red_code, green_code, blue_code
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // x_tristim, y_tristim, z_tristim
);

  logic     f_valid;
  logic     f_ready;
  lin_pix_t f_pix;
  logic     q_valid;
  logic     q_ready;
  lin_pix_t q_pix;

  srgbx_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pix_valid     (f_valid),
    .pix_ready     (f_ready),
    .pix           (f_pix)
  );

  srgbx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_pix   (f_pix),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_pix   (q_pix)
  );

  srgbx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (q_valid),
    .pix_ready     (q_ready),
    .pix           (q_pix),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### rtl/srgbx_checker.sv
// port-level checker for the srgb to xyz converter, bound to the top level
`timescale 1ns / 1ps

module srgbx_checker
  import srgbx_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // front register, queue and five back-end stages
  localparam int MAX_PENDING = 1 + QUEUE_DEPTH + 5;
  localparam int PEND_W      = $clog2(MAX_PENDING + 2);

  logic [PEND_W-1:0] pending;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != '0)
    else $error("result offered with no pixel in flight");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(MAX_PENDING))
    else $error("more pixels in flight than the block can hold");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind srgb_to_xyz_converter srgbx_checker u_checker (.*);

### sim/tb_top.sv
// self-checking testbench for the srgb to xyz converter with its own pixel predictor
`timescale 1ns / 1ps

module tb_top;
  import srgbx_pkg::*;

  typedef struct packed {
    code_t blue;
    code_t green;
    code_t red;
  } pixel_t;

  typedef struct packed {
    tristim_t z;
    tristim_t y;
    tristim_t x;
  } xyz_t;

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_GAPS,
    PH_BACKPRESSURE
  } phase_e;

  localparam int PIX_W          = $bits(pixel_t);
  localparam int XYZ_W          = $bits(xyz_t);
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_LINES      = 30;
  localparam int RAND_PER_PHASE = 170;

  localparam longint unsigned LIN_SHIFT_BITS = 24;
  localparam longint unsigned LIN_UNITY      = 64'd1 << LIN_SHIFT_BITS;
  localparam longint unsigned LIN_ROUND      = 64'd1 << (LIN_SHIFT_BITS - 1);
  localparam longint unsigned FULL_CODE      = (64'd1 << CHANNEL_BITS) - 1;
  localparam longint unsigned TRISTIM_TOP    = (64'd1 << 15) - 1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // red_code, green_code, blue_code
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // x_tristim, y_tristim, z_tristim

  pixel_t pending_pixels [$];
  xyz_t   expected_xyz [$];
  phase_e phase = PH_STEADY;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  int     hold_count = 0;
  logic   hold_done = 1'b0;

  srgb_to_xyz_converter u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // truncating fifth power used by the root search
  function automatic longint unsigned pow5_trunc(input longint unsigned r);
    longint unsigned acc;
    acc = r;
    repeat (4) acc = (acc * r) >> LIN_SHIFT_BITS;
    return acc;
  endfunction

  // srgb transfer function, 24 fraction bits
  function automatic longint unsigned srgb_to_linear(input code_t code);
    longint unsigned c;
    longint unsigned den;
    longint unsigned t;
    longint unsigned q;
    longint unsigned root;
    longint unsigned trial;
    c = code;
    if (c * 100000 <= 4045 * FULL_CODE) begin
      den = 1292 * FULL_CODE;
      return (((c * 100) << LIN_SHIFT_BITS) + den / 2) / den;
    end
    den = 1055 * FULL_CODE;
    t = ((((1000 * c) + (55 * FULL_CODE)) << LIN_SHIFT_BITS) + den / 2) / den;
    q = (t * t + LIN_ROUND) >> LIN_SHIFT_BITS;
    root = 0;
    for (int b = LIN_SHIFT_BITS; b >= 0; b--) begin
      trial = root + (64'd1 << b);
      if (trial <= LIN_UNITY && pow5_trunc(trial) <= q) begin
        root = trial;
      end
    end
    return (q * root + LIN_ROUND) >> LIN_SHIFT_BITS;
  endfunction

  function automatic tristim_t round_tristim(input longint unsigned s);
    longint unsigned den;
    longint unsigned v;
    den = 64'd10000 << LIN_SHIFT_BITS;
    v = ((s << OUT_FRAC_BITS) + den / 2) / den;
    if (v > TRISTIM_TOP) begin
      v = TRISTIM_TOP;
    end
    return tristim_t'(v);
  endfunction

  function automatic xyz_t xyz_from_pixel(input pixel_t pix);
    longint unsigned lr;
    longint unsigned lg;
    longint unsigned lb;
    xyz_t res;
    lr = srgb_to_linear(pix.red);
    lg = srgb_to_linear(pix.green);
    lb = srgb_to_linear(pix.blue);
    res.x = round_tristim(4124 * lr + 3576 * lg + 1805 * lb);
    res.y = round_tristim(2126 * lr + 7152 * lg + 722 * lb);
    res.z = round_tristim(193 * lr + 1192 * lg + 9505 * lb);
    return res;
  endfunction

  // mostly uniform, with extra weight on the extremes and the segment boundary
  function automatic code_t random_code();
    case ($urandom_range(9))
      0: begin
        return $urandom_range(1) ? code_t'(FULL_CODE) : code_t'(0);
      end
      1: begin
        return code_t'($urandom_range(180, 150));
      end
      2: begin
        return code_t'($urandom_range(3));
      end
      default: begin
        return code_t'($urandom);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_LINES) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic push_pixel(input int r, input int g, input int b);
    pixel_t pix;
    pix.red   = code_t'(r);
    pix.green = code_t'(g);
    pix.blue  = code_t'(b);
    pending_pixels.push_back(pix);
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_xyz.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input phase_e ph, input int send_pct, input int recv_pct,
                           input int count);
    phase = ph;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) push_pixel(random_code(), random_code(), random_code());
    wait_drained();
  endtask

  // driver
  always @(posedge clk) begin
    pixel_t next_pix;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_pix = pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - PIX_W){1'b0}}, next_pix};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off in the backpressure phase
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (phase == PH_BACKPRESSURE && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin
    xyz_t got;
    xyz_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_xyz.push_back(xyz_from_pixel(pixel_t'(s_axis_tdata[PIX_W-1:0])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = xyz_t'(m_axis_tdata[XYZ_W-1:0]);
        if (expected_xyz.size() == 0) begin
          report_mismatch("unexpected transaction, x", got.x, 0);
        end else begin
          want = expected_xyz.pop_front();
          if (got.x != want.x) report_mismatch("x_tristim", got.x, want.x);
          if (got.y != want.y) report_mismatch("y_tristim", got.y, want.y);
          if (got.z != want.z) report_mismatch("z_tristim", got.z, want.z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes, single channels, both sides of the segment boundary
    push_pixel(0, 0, 0);
    push_pixel(4095, 4095, 4095);
    push_pixel(4095, 0, 0);
    push_pixel(0, 4095, 0);
    push_pixel(0, 0, 4095);
    push_pixel(165, 165, 165);
    push_pixel(166, 166, 166);
    push_pixel(165, 166, 4095);
    push_pixel(166, 4095, 165);
    push_pixel(1, 1, 1);
    push_pixel(4094, 2048, 1);
    push_pixel(2048, 2048, 2048);
    push_pixel(2730, 1365, 2730);
    push_pixel(1365, 2730, 1365);
    push_pixel(167, 164, 0);
    push_pixel(0, 4095, 166);
    wait_drained();

    run_phase(PH_STEADY, 0, 0, RAND_PER_PHASE);
    run_phase(PH_SEND_GAPS, 49, 0, RAND_PER_PHASE);
    run_phase(PH_RECV_STALLS, 0, 49, RAND_PER_PHASE);
    run_phase(PH_BOTH_GAPS, 12, 12, RAND_PER_PHASE);
    run_phase(PH_BACKPRESSURE, 0, 0, 40);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_xyz.size() != 0) begin
      report_mismatch("transactions never delivered", 0, expected_xyz.size());
    end
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/srgbx_pkg.sv
rtl/srgbx_lin_rom.sv
rtl/srgbx_front.sv
rtl/srgbx_queue.sv
rtl/srgbx_back.sv
rtl/srgb_to_xyz_converter.sv
rtl/srgbx_checker.sv
sim/tb_top.sv
